// File: rtl/cfi_target_table_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the target table checker
// Shared property wrappers; clock and reset names come from the using module.
// ----------------------------------------------------------------------------
`ifndef CFI_TARGET_TABLE_CHECKER_CORE_MACROS_SVH
`define CFI_TARGET_TABLE_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define CTTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cttc assertion failed");

// next-cycle implication
`define CTTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cttc assertion failed");

`endif

// File: rtl/cttc_pkg.sv
// ----------------------------------------------------------------------------
// cttc_pkg
// Types and codes shared by the target table checker and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cttc_pkg;

  // input transaction
  typedef struct packed {
    logic        op;
    logic [13:0] type_id;
    logic [47:0] target_address;
    logic [60:0] module_handle;
    logic [63:0] trace_word;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] report_type_id;
    logic [47:0] report_address;
    logic [60:0] report_handle;
    logic [8:0]  removed_count;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic        valid;
    logic [13:0] type_id;
    logic [47:0] address;
    logic [60:0] owner;
  } entry_t;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_TRACE  = 1'b1;

  // trace word opcodes (bits 63:62)
  localparam logic [1:0] OPC_CHECK  = 2'd1;
  localparam logic [1:0] OPC_MODULE = 2'd2;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_PASS      = 3'd1;
  localparam logic [2:0] STAT_VIOLATION = 3'd2;
  localparam logic [2:0] STAT_LOAD      = 3'd3;
  localparam logic [2:0] STAT_UNLOADED  = 3'd4;
  localparam logic [2:0] STAT_BAD_OP    = 3'd5;
  localparam logic [2:0] STAT_FULL      = 3'd6;

  localparam logic [8:0] COUNT_MAX = 9'h1FF;

endpackage

`default_nettype wire

// File: rtl/cfi_target_table_checker_core.sv
// ----------------------------------------------------------------------------
// cfi_target_table_checker_core
// Table of allowed indirect-branch targets with insert, check and unload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one transaction: an
//   insert (op = 0) or a trace word (op = 1). Every input transaction yields
//   exactly one result transaction on out_valid/out_stall/out_data.
//   Table entries live in a single-port-write, single-port-read memory that
//   one compare unit scans one entry per cycle.
//   Scan length per transaction kind:
//     load request, bad opcode : no scan, straight to the result
//     insert, check            : stops at the first free slot or the
//                                first hit
//     unload, full, violation  : full scan
//   in_stall is high until the result is loaded, so a new transaction is
//   taken only once the last one's result is in the output register.
//   Reset: a clearing pass over every entry zeroes every valid bit;
//   in_stall stays high until it is done.
//   A stalled result holds in the output register; the next transaction may
//   be accepted and scanned meanwhile, and finishes once the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module cfi_target_table_checker_core
  import cttc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // scan kinds
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CHECK  = 2'd1;
  localparam logic [1:0] MODE_UNLOAD = 2'd2;

  logic [1:0]       state_r,   state_nxt;
  logic [1:0]       mode_r,    mode_nxt;
  logic [CNT_W-1:0] idx_r,     idx_nxt;     // next entry to read
  logic             pend_r,    pend_nxt;    // rdata_r holds an entry to compare
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt; // index of the entry in rdata_r
  logic [13:0]      key_type_r, key_type_nxt;
  logic [47:0]      key_addr_r, key_addr_nxt;
  logic [60:0]      key_hdl_r,  key_hdl_nxt;
  logic [8:0]       cnt_r,     cnt_nxt;
  logic [2:0]       stat_r,    stat_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r,  out_data_nxt;

  // entry memory
  entry_t           mem [TABLE_DEPTH];
  entry_t           rdata_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  logic             hit_check;
  logic             hit_owner;
  logic             out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // shared compare unit: one stored entry against the key per cycle
  assign hit_check = rdata_r.valid && (rdata_r.type_id == key_type_r) &&
                     (rdata_r.address == key_addr_r);
  assign hit_owner = rdata_r.valid && (rdata_r.owner == key_hdl_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    cmp_idx_nxt  = cmp_idx_r;
    key_type_nxt = key_type_r;
    key_addr_nxt = key_addr_r;
    key_hdl_nxt  = key_hdl_r;
    cnt_nxt      = cnt_r;
    stat_nxt     = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en   = 1'b0;
    rd_addr = idx_r[IDX_W-1:0];
    we      = 1'b0;
    waddr   = cmp_idx_r;
    wdata   = rdata_r;

    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = idx_r[IDX_W-1:0];
        wdata   = '0;
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r == LAST_CNT) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          cnt_nxt  = '0;
          if (in_data.op == OP_INSERT) begin
            mode_nxt     = MODE_INSERT;
            key_type_nxt = in_data.type_id;
            key_addr_nxt = in_data.target_address;
            key_hdl_nxt  = in_data.module_handle;
            state_nxt    = ST_WALK;
          end else begin
            case (in_data.trace_word[63:62])
              OPC_CHECK: begin
                mode_nxt     = MODE_CHECK;
                key_type_nxt = in_data.trace_word[61:48];
                key_addr_nxt = in_data.trace_word[47:0];
                state_nxt    = ST_WALK;
              end
              OPC_MODULE: begin
                key_hdl_nxt = in_data.trace_word[60:0];
                if (in_data.trace_word[61]) begin
                  mode_nxt  = MODE_UNLOAD;
                  state_nxt = ST_WALK;
                end else begin
                  stat_nxt  = STAT_LOAD;
                  state_nxt = ST_FIN;
                end
              end
              default: begin
                stat_nxt  = STAT_BAD_OP;
                state_nxt = ST_FIN;
              end
            endcase
          end
        end
      end

      ST_WALK: begin
        // issue the next read while the previous entry is compared
        if (idx_r < DEPTH_CNT) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
          pend_nxt    = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          case (mode_r)
            MODE_INSERT: begin
              if (!rdata_r.valid) begin
                we        = 1'b1;
                wdata     = '{valid: 1'b1, type_id: key_type_r,
                              address: key_addr_r, owner: key_hdl_r};
                stat_nxt  = STAT_INSERTED;
                state_nxt = ST_FIN;
              end
            end
            MODE_CHECK: begin
              if (hit_check) begin
                stat_nxt  = STAT_PASS;
                state_nxt = ST_FIN;
              end
            end
            MODE_UNLOAD: begin
              if (hit_owner) begin
                we          = 1'b1;
                wdata.valid = 1'b0;
                if (cnt_r != COUNT_MAX) begin
                  cnt_nxt = cnt_r + 9'd1;
                end
              end
            end
            default: begin
              stat_nxt  = STAT_BAD_OP;
              state_nxt = ST_FIN;
            end
          endcase
        end else if (idx_r == DEPTH_CNT) begin
          // scan exhausted
          state_nxt = ST_FIN;
          case (mode_r)
            MODE_INSERT: stat_nxt = STAT_FULL;
            MODE_CHECK:  stat_nxt = STAT_VIOLATION;
            MODE_UNLOAD: stat_nxt = STAT_UNLOADED;
            default:     stat_nxt = STAT_BAD_OP;
          endcase
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = stat_r;
          if (stat_r == STAT_PASS || stat_r == STAT_VIOLATION) begin
            out_data_nxt.report_type_id = key_type_r;
            out_data_nxt.report_address = key_addr_r;
          end
          if (stat_r == STAT_LOAD || stat_r == STAT_UNLOADED) begin
            out_data_nxt.report_handle = key_hdl_r;
          end
          if (stat_r == STAT_UNLOADED) begin
            out_data_nxt.removed_count = cnt_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    key_type_r <= key_type_nxt;
    key_addr_r <= key_addr_nxt;
    key_hdl_r  <= key_hdl_nxt;
    cnt_r      <= cnt_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/cttc_checker.sv
// ----------------------------------------------------------------------------
// cttc_checker
// Port-level assertions for the target table checker, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cfi_target_table_checker_core_macros.svh"

module cttc_checker
  import cttc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  logic in_acc;
  logic is_check;

  assign in_acc   = in_valid && !in_stall;
  assign is_check = (out_data.status == STAT_PASS) ||
                    (out_data.status == STAT_VIOLATION);

  // stalled result holds
  `CTTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one transaction at a time: busy right after an accept
  `CTTC_ASSERT_NEXT(a_busy_after_acc, in_acc, in_stall)

  // address and type only reported by a check
  `CTTC_ASSERT_NOW(a_check_fields, out_valid && !is_check,
                   out_data.report_type_id == 14'd0 && out_data.report_address == 48'd0)

  // removal count only reported by an unload
  `CTTC_ASSERT_NOW(a_count_unload, out_valid && out_data.removed_count != 9'd0,
                   out_data.status == STAT_UNLOADED)

endmodule

bind cfi_target_table_checker_core cttc_checker u_cttc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
